// File: src/hmi_pkg.sv
// Shared types, constants and the binning function for the histogram
// mutual information block. No dependencies.
package hmi_pkg;

    localparam int MAX_BINS   = 16;
    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int CELL_W     = 2 * BIN_W;
    localparam int HIST_DEPTH = MAX_BINS * MAX_BINS;
    localparam int CNT_W      = 16;
    localparam int NB_W       = 5;
    localparam int THR_W      = 17;
    localparam int LN_W       = 24;
    localparam int LNK_W      = 20;
    localparam int D_W        = 26;
    localparam int PROD_W     = 43;
    localparam int S_W        = 48;
    localparam int DEN_W      = 20;
    localparam int MI_W       = 19;
    localparam int SQ_STEPS   = 20;
    localparam int THP_W      = MI_W + 16 + 2;

    localparam logic [CNT_W-1:0] MAX_SAMPLES = 16'hFFFF;
    localparam logic [31:0]      LN2_Q32     = 32'd2977044472;
    localparam logic [MI_W-1:0]  MI_MAX      = 19'h7FFFF;

    localparam logic KIND_PAIR   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic CFG_NUM_BINS = 1'b0;
    localparam logic CFG_THRESH   = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] first_sample;
        logic signed [15:0] second_sample;
    } item_t;

    typedef struct packed {
        logic [MI_W-1:0]  mutual_info;
        logic             corridor_flag;
        logic [CNT_W-1:0] pair_total;
        logic             overflowed;
    } result_t;

    typedef struct packed {
        logic              upd;
        logic [BIN_W-1:0]  row;
        logic [BIN_W-1:0]  col;
        logic [CELL_W-1:0] raddr;
        logic [BIN_W-1:0]  sel;
        logic              clr;
    } hist_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PAIR,
        ST_LNT,
        ST_LNT_W,
        ST_LNK,
        ST_LNK_W,
        ST_ROW,
        ST_ROW_W,
        ST_COL,
        ST_COL_W,
        ST_CELL_RD,
        ST_CELL_DAT,
        ST_CELL_W,
        ST_CELL_ACC,
        ST_DIV,
        ST_DIV_W,
        ST_THR,
        ST_FLAG
    } hmi_state_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_SQ,
        LN_FIN
    } ln_state_t;

    function automatic logic [BIN_W-1:0] bin_of(input logic signed [15:0] v,
                                                input logic [NB_W-1:0] k);
        logic signed [16:0] c;
        logic [15:0]        u;
        logic [20:0]        p;
        logic [NB_W-1:0]    b;
        c = {v[15], v};
        if (c < -17'sd16384)
        begin
            c = -17'sd16384;
        end
        if (c > 17'sd16384)
        begin
            c = 17'sd16384;
        end
        u = 16'(c + 17'sd16384);
        p = 21'(u) * 21'(k);
        b = NB_W'(p >> 15);
        if (b >= k)
        begin
            b = k - NB_W'(1);
        end
        return b[BIN_W-1:0];
    endfunction

endpackage

// File: src/hmi_ln.sv
// Iterative natural log unit: log2 by repeated mantissa squaring, then
// scaled by ln 2 to Q20. Depends on hmi_pkg.
module hmi_ln (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [15:0]           x,
    output logic                  done,
    output logic [hmi_pkg::LN_W-1:0] res
);
    import hmi_pkg::*;

    ln_state_t       st_reg, st_next;
    logic [31:0]     m_reg, m_next;
    logic [19:0]     frac_reg, frac_next;
    logic [3:0]      e_reg, e_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [LN_W-1:0] res_reg, res_next;

    logic [3:0]  e_c;
    logic [63:0] sq;
    logic [32:0] sh;
    logic [55:0] fin;

    always_comb
    begin
        e_c = 4'd0;
        for (int b = 0; b < 16; b++)
        begin
            if (x[b])
            begin
                e_c = 4'(b);
            end
        end
        sq  = 64'(m_reg) * 64'(m_reg);
        sh  = 33'(sq >> 31);
        fin = 56'({e_reg, frac_reg}) * 56'(LN2_Q32) + 56'h80000000;

        st_next   = st_reg;
        m_next    = m_reg;
        frac_next = frac_reg;
        e_next    = e_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        case (st_reg)
            LN_IDLE:
            begin
                if (start)
                begin
                    e_next    = e_c;
                    m_next    = 32'(x) << (5'd31 - {1'b0, e_c});
                    frac_next = '0;
                    cnt_next  = '0;
                    st_next   = LN_SQ;
                end
            end
            LN_SQ:
            begin
                if (sh[32])
                begin
                    m_next    = sh[32:1];
                    frac_next = {frac_reg[18:0], 1'b1};
                end
                else
                begin
                    m_next    = sh[31:0];
                    frac_next = {frac_reg[18:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQ_STEPS - 1))
                begin
                    st_next = LN_FIN;
                end
            end
            LN_FIN:
            begin
                res_next  = fin[55:32];
                done_next = 1'b1;
                st_next   = LN_IDLE;
            end
            default:
            begin
                st_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= LN_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        frac_reg <= frac_next;
        e_reg    <= e_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;
endmodule

// File: src/hmi_div.sv
// Restoring divider, one quotient bit per cycle, for the final MI scaling.
// Depends on hmi_pkg.
module hmi_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hmi_pkg::S_W-1:0]   num,
    input  logic [hmi_pkg::DEN_W-1:0] den,
    output logic                      done,
    output logic [hmi_pkg::S_W-1:0]   quo
);
    import hmi_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [S_W-1:0]   q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, q_reg[S_W-1]};
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                cnt_next  = '0;
                q_next    = num;
                rem_next  = '0;
                den_next  = den;
            end
        end
        else
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                q_next   = {q_reg[S_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                q_next   = {q_reg[S_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(S_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

// File: src/hmi_hist.sv
// Joint histogram memory with per-entry valid bits, plus row and column
// marginal counters. Depends on hmi_pkg.
module hmi_hist (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hmi_pkg::hist_ctl_t        ctl,
    output logic [hmi_pkg::CNT_W-1:0] n,
    output logic [hmi_pkg::CNT_W-1:0] row_q,
    output logic [hmi_pkg::CNT_W-1:0] col_q
);
    import hmi_pkg::*;

    logic [CNT_W-1:0]      mem [HIST_DEPTH];
    logic [CNT_W-1:0]      rdata_reg;
    logic                  vq_reg;
    logic [HIST_DEPTH-1:0] vld_reg;
    logic                  pend_reg;
    logic [CELL_W-1:0]     paddr_reg;
    logic [CNT_W-1:0]      row_reg [MAX_BINS];
    logic [CNT_W-1:0]      col_reg [MAX_BINS];
    logic [CELL_W-1:0]     raddr;
    logic [CNT_W-1:0]      cur;
    logic [CNT_W-1:0]      wdata;

    assign raddr = ctl.upd ? {ctl.row, ctl.col} : ctl.raddr;
    assign cur   = vq_reg ? rdata_reg : '0;
    assign wdata = cur + CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            mem[paddr_reg] <= wdata;
        end
        rdata_reg <= mem[raddr];
        paddr_reg <= raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            vq_reg   <= 1'b0;
            pend_reg <= 1'b0;
            for (int b = 0; b < MAX_BINS; b++)
            begin
                row_reg[b] <= '0;
                col_reg[b] <= '0;
            end
        end
        else
        begin
            vq_reg   <= vld_reg[raddr];
            pend_reg <= ctl.upd;
            if (ctl.clr)
            begin
                vld_reg <= '0;
                for (int b = 0; b < MAX_BINS; b++)
                begin
                    row_reg[b] <= '0;
                    col_reg[b] <= '0;
                end
            end
            else
            begin
                if (pend_reg)
                begin
                    vld_reg[paddr_reg] <= 1'b1;
                end
                if (ctl.upd)
                begin
                    row_reg[ctl.row] <= row_reg[ctl.row] + CNT_W'(1);
                    col_reg[ctl.col] <= col_reg[ctl.col] + CNT_W'(1);
                end
            end
        end
    end

    assign n     = cur;
    assign row_q = row_reg[ctl.sel];
    assign col_q = col_reg[ctl.sel];
endmodule

// File: src/histogram_mutual_information.sv
// Histogram mutual information estimator, top level with the sequencer.
// Depends on hmi_pkg, hmi_hist, hmi_ln and hmi_div.
//
// Usage:
//   item/item_valid/item_stall carry input words; a word is taken when
//   item_valid is high and item_stall low. A pair word (kind 0) bins both
//   samples and updates the joint histogram by read-modify-write of the
//   histogram memory; item_stall stays high while the write-back finishes.
//   A finish word (kind 1) walks the histogram and returns one result word
//   on result/result_valid/result_stall. Finish runs the iterative log
//   unit on the pair total, the bin count, every marginal and every nonzero
//   cell, then the divider if the weighted sum is positive; an empty series
//   skips both.
//   The result sits in an output register; while result_stall is high it
//   holds, and a finish ready to emit waits for the slot to free.
//   cfg_index/cfg_data write num_bins (0) or the threshold (1);
//   cfg_ready is always high. Reset loads 10 and 19661 and clears all
//   histogram state at once; the histogram also clears after each finish.
module histogram_mutual_information (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  hmi_pkg::item_t            item,
    output logic                      result_valid,
    input  logic                      result_stall,
    output hmi_pkg::result_t          result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [hmi_pkg::THR_W-1:0] cfg_data
);
    import hmi_pkg::*;

    hmi_state_t        state_reg, state_next;
    logic [NB_W-1:0]   nb_reg, nb_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic [CNT_W-1:0]  pairs_reg, pairs_next;
    logic              drop_reg, drop_next;
    logic [BIN_W-1:0]  idx_reg, idx_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [LN_W-1:0]   lnt_reg, lnt_next;
    logic [LNK_W-1:0]  lnk_reg, lnk_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [S_W-1:0]    s_reg, s_next;
    logic [MI_W-1:0]   mi_reg, mi_next;
    logic [THP_W-1:0]  thp_reg, thp_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [LN_W-1:0]   lnrow_reg [MAX_BINS];
    logic [LN_W-1:0]   lncol_reg [MAX_BINS];

    hist_ctl_t         ctl;
    logic [CNT_W-1:0]  hist_n, row_q, col_q;
    logic              ln_start, ln_done;
    logic [15:0]       ln_x;
    logic [LN_W-1:0]   ln_res;
    logic              div_start, div_done;
    logic [S_W-1:0]    div_num, div_quo;
    logic [DEN_W-1:0]  div_den;
    logic              row_we, col_we;
    logic [NB_W-1:0]   k;
    logic              in_take, out_free, func;
    logic signed [D_W-1:0] d;

    hmi_hist u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .n     (hist_n),
        .row_q (row_q),
        .col_q (col_q)
    );

    hmi_ln u_ln (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ln_start),
        .x     (ln_x),
        .done  (ln_done),
        .res   (ln_res)
    );

    hmi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != ST_IDLE);
    assign in_take      = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign out_free     = !out_valid_reg || !result_stall;

    assign k = (nb_reg == '0) ? NB_W'(1)
             : (nb_reg > NB_W'(MAX_BINS)) ? NB_W'(MAX_BINS) : nb_reg;

    assign div_num = S_W'(s_reg) + S_W'({pairs_reg, 3'b000});
    assign div_den = {pairs_reg, 4'b0000};

    assign d = $signed({2'b00, ln_res}) + $signed({2'b00, lnt_reg})
             - $signed({2'b00, lnrow_reg[cell_reg[CELL_W-1:BIN_W]]})
             - $signed({2'b00, lncol_reg[cell_reg[BIN_W-1:0]]});

    assign func = (pairs_reg != '0)
               && ((k == NB_W'(1)) ? (thr_reg == '0)
                                   : (THP_W'({mi_reg, 16'h0000}) >= thp_reg));

    always_comb
    begin
        state_next     = state_reg;
        nb_next        = nb_reg;
        thr_next       = thr_reg;
        pairs_next     = pairs_reg;
        drop_next      = drop_reg;
        idx_next       = idx_reg;
        cell_next      = cell_reg;
        n_next         = n_reg;
        lnt_next       = lnt_reg;
        lnk_next       = lnk_reg;
        prod_next      = prod_reg;
        s_next         = s_reg;
        mi_next        = mi_reg;
        thp_next       = thp_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        ln_start       = 1'b0;
        ln_x           = '0;
        div_start      = 1'b0;
        row_we         = 1'b0;
        col_we         = 1'b0;
        ctl.upd        = 1'b0;
        ctl.row        = bin_of(item.first_sample, k);
        ctl.col        = bin_of(item.second_sample, k);
        ctl.raddr      = cell_reg;
        ctl.sel        = idx_reg;
        ctl.clr        = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_NUM_BINS)
            begin
                nb_next = cfg_data[NB_W-1:0];
            end
            else
            begin
                thr_next = cfg_data;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (item.kind == KIND_PAIR)
                    begin
                        if (pairs_reg >= MAX_SAMPLES)
                        begin
                            drop_next = 1'b1;
                        end
                        else
                        begin
                            ctl.upd    = 1'b1;
                            pairs_next = pairs_reg + CNT_W'(1);
                            state_next = ST_PAIR;
                        end
                    end
                    else if (pairs_reg == '0)
                    begin
                        mi_next    = '0;
                        state_next = ST_FLAG;
                    end
                    else
                    begin
                        state_next = ST_LNT;
                    end
                end
            end
            ST_PAIR:
            begin
                state_next = ST_IDLE;
            end
            ST_LNT:
            begin
                ln_start   = 1'b1;
                ln_x       = pairs_reg;
                state_next = ST_LNT_W;
            end
            ST_LNT_W:
            begin
                if (ln_done)
                begin
                    lnt_next   = ln_res;
                    state_next = ST_LNK;
                end
            end
            ST_LNK:
            begin
                ln_start   = 1'b1;
                ln_x       = 16'(k);
                state_next = ST_LNK_W;
            end
            ST_LNK_W:
            begin
                if (ln_done)
                begin
                    lnk_next   = LNK_W'((ln_res + LN_W'(8)) >> 4);
                    idx_next   = '0;
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                ln_start   = 1'b1;
                ln_x       = row_q;
                state_next = ST_ROW_W;
            end
            ST_ROW_W:
            begin
                if (ln_done)
                begin
                    row_we   = 1'b1;
                    idx_next = idx_reg + BIN_W'(1);
                    if (idx_reg == BIN_W'(MAX_BINS - 1))
                    begin
                        state_next = ST_COL;
                    end
                    else
                    begin
                        state_next = ST_ROW;
                    end
                end
            end
            ST_COL:
            begin
                ln_start   = 1'b1;
                ln_x       = col_q;
                state_next = ST_COL_W;
            end
            ST_COL_W:
            begin
                if (ln_done)
                begin
                    col_we   = 1'b1;
                    idx_next = idx_reg + BIN_W'(1);
                    if (idx_reg == BIN_W'(MAX_BINS - 1))
                    begin
                        cell_next  = '0;
                        s_next     = '0;
                        state_next = ST_CELL_RD;
                    end
                    else
                    begin
                        state_next = ST_COL;
                    end
                end
            end
            ST_CELL_RD:
            begin
                state_next = ST_CELL_DAT;
            end
            ST_CELL_DAT:
            begin
                n_next = hist_n;
                if (hist_n == '0)
                begin
                    cell_next = cell_reg + CELL_W'(1);
                    if (cell_reg == '1)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_CELL_RD;
                    end
                end
                else
                begin
                    ln_start   = 1'b1;
                    ln_x       = hist_n;
                    state_next = ST_CELL_W;
                end
            end
            ST_CELL_W:
            begin
                if (ln_done)
                begin
                    prod_next  = $signed({1'b0, n_reg}) * d;
                    state_next = ST_CELL_ACC;
                end
            end
            ST_CELL_ACC:
            begin
                s_next    = s_reg + S_W'(prod_reg);
                cell_next = cell_reg + CELL_W'(1);
                if (cell_reg == '1)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_CELL_RD;
                end
            end
            ST_DIV:
            begin
                if (s_reg <= 0)
                begin
                    mi_next    = '0;
                    state_next = ST_THR;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_W;
                end
            end
            ST_DIV_W:
            begin
                if (div_done)
                begin
                    if (div_quo > S_W'(MI_MAX))
                    begin
                        mi_next = MI_MAX;
                    end
                    else
                    begin
                        mi_next = div_quo[MI_W-1:0];
                    end
                    state_next = ST_THR;
                end
            end
            ST_THR:
            begin
                thp_next   = THP_W'(thr_reg) * THP_W'(lnk_reg);
                state_next = ST_FLAG;
            end
            ST_FLAG:
            begin
                if (out_free)
                begin
                    out_next.mutual_info   = mi_reg;
                    out_next.corridor_flag = func;
                    out_next.pair_total    = pairs_reg;
                    out_next.overflowed    = drop_reg;
                    out_valid_next         = 1'b1;
                    ctl.clr                = 1'b1;
                    pairs_next             = '0;
                    drop_next              = 1'b0;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nb_reg        <= NB_W'(10);
            thr_reg       <= THR_W'(19661);
            pairs_reg     <= '0;
            drop_reg      <= 1'b0;
            idx_reg       <= '0;
            cell_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nb_reg        <= nb_next;
            thr_reg       <= thr_next;
            pairs_reg     <= pairs_next;
            drop_reg      <= drop_next;
            idx_reg       <= idx_next;
            cell_reg      <= cell_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        lnt_reg  <= lnt_next;
        lnk_reg  <= lnk_next;
        prod_reg <= prod_next;
        s_reg    <= s_next;
        mi_reg   <= mi_next;
        thp_reg  <= thp_next;
        out_reg  <= out_next;
        if (row_we)
        begin
            lnrow_reg[idx_reg] <= ln_res;
        end
        if (col_we)
        begin
            lncol_reg[idx_reg] <= ln_res;
        end
    end
endmodule
